FILE: sv/fpa_pkg.sv
// Shared types and constants for the fixed-point ALU.
package fpa_pkg;

  localparam int FRACTION_BITS_DEF = 8;
  localparam int WORD_BITS_DEF     = 32;
  localparam int IO_BITS           = 32;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_MIN      = 4'd4,
    OP_MAX      = 4'd5,
    OP_INC      = 4'd6,
    OP_DEC      = 4'd7,
    OP_TO_INT   = 4'd8,
    OP_FROM_INT = 4'd9
  } op_t;

  typedef struct packed {
    logic a_greater;
    logic a_less;
    logic a_equal;
  } cmp_flags_t;

endpackage

FILE: sv/fpa_if.sv
// Valid/ready channel interfaces for the fixed-point ALU.
interface fpa_in_if;
  import fpa_pkg::*;
  logic               valid;
  logic               ready;
  logic [3:0]         operation;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, operation, operand_a, operand_b, input ready);
  modport sink   (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               a_greater;
  logic               a_less;
  logic               a_equal;
  logic               overflowed;
  logic               divide_by_zero;
  modport source (output valid, result_value, a_greater, a_less, a_equal,
                  overflowed, divide_by_zero, input ready);
  modport sink   (input valid, result_value, a_greater, a_less, a_equal,
                  overflowed, divide_by_zero, output ready);
endinterface

FILE: sv/fpa_cell.sv
// One stage of the ALU chain: carries an item and one restoring divide step.
module fpa_cell #(
  parameter int WORD_BITS = 32,
  parameter int QB        = 48,
  parameter int DB        = 32,
  parameter int STEP      = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          v_in,
  input  logic [QB-1:0] rem_in,
  input  logic [QB-1:0] num_in,
  input  logic [DB-1:0] den_in,
  input  logic [QB-1:0] quo_in,
  input  logic [WORD_BITS+1:0] side_in,
  output logic          v_out,
  output logic [QB-1:0] rem_out,
  output logic [QB-1:0] num_out,
  output logic [DB-1:0] den_out,
  output logic [QB-1:0] quo_out,
  output logic [WORD_BITS+1:0] side_out
);
  import fpa_pkg::*;
  localparam int BIT = QB - 1 - STEP;

  logic [QB:0]   trial;
  logic [QB-1:0] rem_nxt;
  logic          qbit;
  logic          v_r;
  logic [QB-1:0] rem_r, num_r, quo_r;
  logic [DB-1:0] den_r;
  logic [WORD_BITS+1:0] side_r;

  always_comb begin
    trial   = {rem_in, num_in[BIT]} - {{(QB+1-DB){1'b0}}, den_in};
    qbit    = ~trial[QB];
    rem_nxt = qbit ? trial[QB-1:0] : {rem_in[QB-2:0], num_in[BIT]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_in;
    end
    if (adv) begin
      rem_r  <= rem_nxt;
      num_r  <= num_in;
      den_r  <= den_in;
      quo_r  <= quo_in | (QB'(qbit) << BIT);
      side_r <= side_in;
    end
  end

  assign v_out    = v_r;
  assign rem_out  = rem_r;
  assign num_out  = num_r;
  assign den_out  = den_r;
  assign quo_out  = quo_r;
  assign side_out = side_r;
endmodule

FILE: sv/fixed_point_alu_core.sv
// Top level of the pipelined signed fixed-point ALU.
// Usage:
//   Input channel in_* carries operation, operand_a, operand_b; one transfer
//   per valid&ready edge. Result channel out_* carries result_value, compare
//   flags, overflowed and divide_by_zero, one result per input in order.
// Throughput: one item per cycle unless stalled. Every item goes down the
//   same chain. Stages: one decode stage (magnitudes, fixed results), one
//   divide cell per quotient bit, one multiply stage, one
//   rounding/saturation stage feeding the output register. The multiply is
//   one 32x32 product between registers.
// Stall: the whole chain advances only when the output register is empty
//   or being drained, so in_ready is high whenever the output is free or
//   taken this cycle; a stalled result holds with nothing lost.
// Reset: rst_n synchronous active low clears all valid bits; the pipeline
//   is empty and in_ready is high after reset.
module fixed_point_alu_core #(
  parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF,
  parameter int WORD_BITS     = fpa_pkg::WORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  fpa_in_if.sink    in_ch,
  fpa_out_if.source out_ch
);
  import fpa_pkg::*;
  localparam int W  = WORD_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int QB = W + F;       // quotient / numerator bits
  localparam int DB = W;           // divisor magnitude bits
  localparam int NC = QB;          // divide cells
  localparam int SB = W + 2;       // side band width; tied to zero at the chain input

  // Per-item control carried alongside the divide chain.
  typedef struct packed {
    logic [3:0]   op;
    logic         neg;
    logic         dz;
    logic         a_neg;
    logic [W-1:0] ma;
    logic [W-1:0] mb;
    logic signed [W+1:0] fixed_res;  // already computed, pre-clamp
    cmp_flags_t   cmp;
  } ctl_t;

  logic adv;
  logic out_v_r;
  assign adv         = ~out_v_r | out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------- decode stage ----------------
  logic signed [W-1:0] a, b;
  logic signed [W+1:0] fx;
  ctl_t c0_nxt, c0_r;
  logic v0_r;
  assign a = in_ch.operand_a[W-1:0];
  assign b = in_ch.operand_b[W-1:0];

  always_comb begin
    fx = '0;
    case (in_ch.operation)
      OP_ADD: fx = (W+2)'(a) + (W+2)'(b);
      OP_SUB: fx = (W+2)'(a) - (W+2)'(b);
      OP_MIN: fx = (a < b) ? (W+2)'(a) : (W+2)'(b);
      OP_MAX: fx = (a > b) ? (W+2)'(a) : (W+2)'(b);
      OP_INC: fx = (W+2)'(a) + (W+2)'(1);
      OP_DEC: fx = (W+2)'(a) - (W+2)'(1);
      OP_TO_INT: fx = (W+2)'(a >>> F);
      default: fx = '0;
    endcase
    c0_nxt.op        = in_ch.operation;
    c0_nxt.neg       = a[W-1] ^ b[W-1];
    c0_nxt.dz        = (b == '0);
    c0_nxt.a_neg     = a[W-1];
    c0_nxt.ma        = a[W-1] ? W'(-a) : W'(a);
    c0_nxt.mb        = b[W-1] ? W'(-b) : W'(b);
    c0_nxt.fixed_res = fx;
    c0_nxt.cmp.a_greater = a > b;
    c0_nxt.cmp.a_less    = a < b;
    c0_nxt.cmp.a_equal   = a == b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_ch.valid;
    end
    if (adv) begin
      c0_r <= c0_nxt;
    end
  end

  // ---------------- divide chain ----------------
  // Quotient floor(ma*2^F / mb); rounding uses the final remainder.
  logic [NC:0]        cv;
  logic [QB-1:0]      crem [NC+1];
  logic [QB-1:0]      cnum [NC+1];
  logic [DB-1:0]      cden [NC+1];
  logic [QB-1:0]      cquo [NC+1];
  logic [SB-1:0]      cside[NC+1];
  ctl_t               cctl [NC+1];

  assign cv[0]    = v0_r;
  assign crem[0]  = '0;
  assign cnum[0]  = {c0_r.ma, F'(0)};
  assign cden[0]  = c0_r.mb;
  assign cquo[0]  = '0;
  assign cside[0] = '0;
  assign cctl[0]  = c0_r;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    fpa_cell #(.WORD_BITS(W), .QB(QB), .DB(DB), .STEP(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .v_in(cv[i]), .rem_in(crem[i]), .num_in(cnum[i]), .den_in(cden[i]),
      .quo_in(cquo[i]), .side_in(cside[i]),
      .v_out(cv[i+1]), .rem_out(crem[i+1]), .num_out(cnum[i+1]),
      .den_out(cden[i+1]), .quo_out(cquo[i+1]), .side_out(cside[i+1])
    );
    // control struct rides along in a plain register per cell
    ctl_t ctl_r;
    always_ff @(posedge clk) begin
      if (adv) begin
        ctl_r <= cctl[i];
      end
    end
    assign cctl[i+1] = ctl_r;
  end

  // ---------------- multiply stage ----------------
  logic [2*W-1:0] prod_r;
  logic [QB-1:0]  quo_r;
  logic           rup_r;
  ctl_t           c1_r;
  logic           v1_r;
  logic [QB:0]    rem2;
  assign rem2 = {crem[NC], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= cv[NC];
    end
    if (adv) begin
      prod_r <= (2*W)'(cctl[NC].ma) * (2*W)'(cctl[NC].mb);
      quo_r  <= cquo[NC];
      rup_r  <= rem2 >= (QB+1)'(cden[NC]);   // 2*rem >= den: round up
      c1_r   <= cctl[NC];
    end
  end

  // ---------------- round and saturate ----------------
  localparam logic signed [W+F+2:0] WMAX = (W+F+3)'((64'sd1 <<< (W-1)) - 1);
  localparam logic signed [W+F+2:0] WMIN = -WMAX - 1;
  logic [2*W-1:0]          pq;
  logic [QB:0]             dq;
  logic [W+F+1:0]          mag;
  logic signed [W+F+2:0]   sv;
  logic signed [W-1:0]     res;
  logic                    ovf, dzf;

  always_comb begin
    pq  = (prod_r + (2*W)'(1 << (F-1))) >> F;
    dq  = (QB+1)'(quo_r) + (QB+1)'(rup_r);
    mag = '0;
    sv  = '0;
    case (c1_r.op)
      OP_MUL: begin
        mag = (|pq[2*W-1:W+F+1]) ? {(W+F+2){1'b1}} : pq[W+F+1:0];
        sv  = c1_r.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
      OP_DIV: begin
        mag = (W+F+2)'(dq);
        sv  = c1_r.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
      OP_FROM_INT: sv = (W+F+3)'($signed(c1_r.a_neg ? -{1'b0, c1_r.ma}
                                                      : {1'b0, c1_r.ma})) <<< F;
      OP_ADD, OP_SUB, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_TO_INT:
        sv = (W+F+3)'(c1_r.fixed_res);
      default: sv = '0;
    endcase
    dzf = (c1_r.op == OP_DIV) && c1_r.dz;
    ovf = 1'b0;
    if (dzf) begin
      res = c1_r.a_neg ? W'(WMIN) : W'(WMAX);
      ovf = 1'b1;
    end else if (sv > WMAX) begin
      res = W'(WMAX);
      ovf = 1'b1;
    end else if (sv < WMIN) begin
      res = W'(WMIN);
      ovf = 1'b1;
    end else begin
      res = W'(sv);
    end
  end

  // ---------------- output register ----------------
  logic signed [31:0] res_r;
  cmp_flags_t         cmp_r;
  logic               ovf_r, dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= v1_r;
    end
    if (adv) begin
      res_r <= IO_BITS'(res);
      cmp_r <= c1_r.cmp;
      ovf_r <= ovf;
      dz_r  <= dzf;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.result_value   = res_r;
  assign out_ch.a_greater      = cmp_r.a_greater;
  assign out_ch.a_less         = cmp_r.a_less;
  assign out_ch.a_equal        = cmp_r.a_equal;
  assign out_ch.overflowed     = ovf_r;
  assign out_ch.divide_by_zero = dz_r;
endmodule
